// ===== design/qph_pkg.sv =====
// Shared types and constants for the quadratic-probe hash table.
// Used by the controller, the datapath and the top level; depends on nothing.
package qph_pkg;

  // Field widths fixed by the stream format
  localparam int KEY_W       = 23;  // key in hundredths
  localparam int WHOLE_W     = 16;
  localparam int CENTS_W     = 7;
  localparam int SIZE_W      = 7;
  localparam int SLOT_OUT_W  = 6;
  localparam int ENTRY_W     = 7;
  localparam int COLL_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SLOT_OUT_W - ENTRY_W - COLL_W;

  // Size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd29;

  // Home hash reduction: 18-bit dividend, 3 bits per step
  localparam int BASE_W    = 18;
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = BASE_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Probe counter holds up to size + 1
  localparam int PROBE_W = SIZE_W + 1;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_FOUND    = 2'd2;
  localparam status_t ST_MISSING  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // capture the input beat
    logic    mod_step;    // one step of the home-slot reduction
    logic    probe_init;  // start the probe walk at the home slot
    logic    probe_adv;   // move to the next quadratic probe
    logic    ins_commit;  // store key at the current slot
    logic    coll_inc;    // count one occupied slot passed
    logic    res_set;     // latch result status and slot
    status_t res_status;
    logic    res_hit;     // slot index is the current slot, else zero
    logic    out_load;    // move the result into the output register
  } qph_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op;         // captured opcode
    logic mod_last;   // final reduction step
    logic used;       // current slot occupied
    logic key_match;  // stored key equals the search key
    logic ins_last;   // insert has reached its last probe
    logic srch_last;  // search has reached its last probe
    logic out_free;   // output register can take a result
  } qph_stat_t;

endpackage

// ===== design/qph_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/qph_ctrl.sv =====
// Controller state machine for the quadratic-probe hash table.
// Depends on qph_pkg; drives the datapath through qph_cmd_t.
module qph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qph_pkg::qph_stat_t stat,
  output qph_pkg::qph_cmd_t  cmd
);
  import qph_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MOD      = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_SRCH_RD  = 3'd3;
  localparam logic [2:0] S_SRCH_CHK = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          cmd.probe_init = 1'b1;
          state_nxt      = (stat.op == OP_INSERT) ? S_INS : S_SRCH_RD;
        end
      end
      S_INS: begin
        if (!stat.used) begin
          cmd.ins_commit = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_INSERTED;
          cmd.res_hit    = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.coll_inc = 1'b1;
          if (stat.ins_last) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end
      end
      S_SRCH_RD: begin
        // wait for the key read of the current slot
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        priority if (!stat.used) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_MISSING;
          state_nxt      = S_DONE;
        end else if (stat.key_match) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_hit    = 1'b1;
          state_nxt      = S_DONE;
        end else if (stat.srch_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_MISSING;
          state_nxt      = S_DONE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/qph_dp.sv =====
// Datapath for the quadratic-probe hash table: key capture, home-slot
// reduction, probe walk, occupancy bits, key RAM, counters, output register.
// Depends on qph_pkg and qph_ram.
module qph_dp #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [qph_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [qph_pkg::SIZE_W-1:0]           cfg_wr_data,
  input  logic                                 out_tready,
  input  qph_pkg::qph_cmd_t                    cmd,
  output qph_pkg::qph_stat_t                   stat,
  output logic                                 out_tvalid,
  output logic [qph_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [qph_pkg::STATUS_W-1:0]         out_tuser
);
  import qph_pkg::*;

  // A 7-bit size cannot reach beyond 127 slots
  localparam int SLOTS = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
  localparam int IW    = $clog2(SLOTS);

  logic                    op_r;
  logic [KEY_W-1:0]        key_r;
  logic [BASE_W-1:0]       div_r;
  logic [SIZE_W-1:0]       rem_r;
  logic [DIV_CNT_W-1:0]    mod_cnt_r;
  logic [SIZE_W-1:0]       pos_r, pos_nxt;
  logic [SIZE_W-1:0]       step_r, step_nxt, step_init;
  logic [PROBE_W-1:0]      probe_cnt_r;
  logic [SLOTS-1:0]        used_r;
  logic [ENTRY_W-1:0]      entry_cnt_r;
  logic [COLL_W-1:0]       coll_cnt_r;
  logic [SIZE_W-1:0]       size_r;
  logic [SIZE_W-1:0]       size_eff;
  status_t                 res_status_r;
  logic [SIZE_W-1:0]       res_slot_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  logic [ENTRY_W-1:0]      out_entry_r;
  logic [COLL_W-1:0]       out_coll_r;

  logic [WHOLE_W-1:0]      key_whole;
  logic [CENTS_W-1:0]      key_cents;
  logic                    cents_hi;
  logic [WHOLE_W:0]        w_adj;
  logic [CENTS_W-1:0]      f_adj;
  logic [BASE_W-1:0]       base_in;
  logic [KEY_W-1:0]        key_in;
  logic [SIZE_W-1:0]       rem_step;
  logic [SIZE_W:0]         psum, ssum;
  logic [KEY_W-1:0]        ram_rdata;
  logic [IW-1:0]           slot_idx;

  // Slot count in use: zero acts as one, clamp to the table depth
  always_comb begin
    priority if (size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_r > SIZE_W'(SLOTS)) begin
      size_eff = SIZE_W'(SLOTS);
    end else begin
      size_eff = size_r;
    end
  end

  // Normalize the key: cents of a hundred or more carry into the whole part
  assign key_whole = in_tdata[WHOLE_W-1:0];
  assign key_cents = in_tdata[WHOLE_W+CENTS_W-1:WHOLE_W];
  assign cents_hi  = (key_cents >= CENTS_W'(100));
  assign w_adj     = {1'b0, key_whole} + (WHOLE_W+1)'(cents_hi);
  assign f_adj     = cents_hi ? (key_cents - CENTS_W'(100)) : key_cents;
  assign base_in   = BASE_W'({w_adj, 1'b0}) + BASE_W'({f_adj, 1'b0}) + BASE_W'(f_adj);
  assign key_in    = KEY_W'(key_whole) * KEY_W'(100) + KEY_W'(key_cents);

  // Home slot reduction: three restoring remainder steps per cycle
  always_comb begin
    logic [SIZE_W:0]      t;
    logic [SIZE_W-1:0]    r;
    logic [DIV_BITS-1:0]  bits;
    r    = rem_r;
    bits = div_r[BASE_W-1 -: DIV_BITS];
    for (int k = DIV_BITS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= {1'b0, size_eff}) begin
        t = t - {1'b0, size_eff};
      end
      r = t[SIZE_W-1:0];
    end
    rem_step = r;
  end

  // Quadratic walk: slot advances by 2(i+1), kept below the size
  assign step_init = (size_eff <= SIZE_W'(2)) ? '0 : SIZE_W'(2);
  assign psum      = {1'b0, pos_r} + {1'b0, step_r};
  assign ssum      = {1'b0, step_r} + (SIZE_W+1)'(2);

  always_comb begin
    pos_nxt = (psum >= {1'b0, size_eff}) ? SIZE_W'(psum - {1'b0, size_eff})
                                         : psum[SIZE_W-1:0];
    priority if (size_eff == SIZE_W'(1)) begin
      step_nxt = '0;
    end else if (ssum >= {1'b0, size_eff}) begin
      step_nxt = SIZE_W'(ssum - {1'b0, size_eff});
    end else begin
      step_nxt = ssum[SIZE_W-1:0];
    end
  end

  assign slot_idx = pos_r[IW-1:0];

  // Key store, read continuously at the current slot
  qph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.ins_commit),
    .waddr (slot_idx),
    .wdata (key_r),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  // Capture, reduction and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      key_r     <= key_in;
      div_r     <= base_in;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      div_r     <= div_r << DIV_BITS;
      rem_r     <= rem_step;
      mod_cnt_r <= mod_cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.probe_init) begin
      pos_r       <= rem_step;
      step_r      <= step_init;
      probe_cnt_r <= '0;
    end else if (cmd.probe_adv) begin
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      probe_cnt_r <= probe_cnt_r + PROBE_W'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_hit ? pos_r : '0;
    end
  end

  // Size register, occupancy bits and counters; a size write empties the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      used_r      <= '0;
      entry_cnt_r <= '0;
      coll_cnt_r  <= '0;
    end else if (cfg_wr_en) begin
      size_r      <= cfg_wr_data;
      used_r      <= '0;
      entry_cnt_r <= '0;
      coll_cnt_r  <= '0;
    end else begin
      if (cmd.ins_commit) begin
        used_r[slot_idx] <= 1'b1;
        entry_cnt_r      <= entry_cnt_r + ENTRY_W'(1);
      end
      if (cmd.coll_inc && (coll_cnt_r != '1)) begin
        coll_cnt_r <= coll_cnt_r + COLL_W'(1);
      end
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r[SLOT_OUT_W-1:0];
      out_entry_r  <= entry_cnt_r;
      out_coll_r   <= coll_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_coll_r, out_entry_r, out_slot_r};

  // Status to the controller
  assign stat.op        = op_r;
  assign stat.mod_last  = (mod_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.used      = used_r[slot_idx];
  assign stat.key_match = (ram_rdata == key_r);
  assign stat.ins_last  = (probe_cnt_r == ({1'b0, size_eff} - PROBE_W'(1)));
  assign stat.srch_last = (probe_cnt_r == {1'b0, size_eff});
  assign stat.out_free  = !out_valid_r || out_tready;

  // Checks
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= size_eff)
    else $error("entry count exceeds table size");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (entry_cnt_r == '0) && (coll_cnt_r == '0) && (used_r == '0))
    else $error("size write did not empty the table");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_commit |-> !used_r[slot_idx])
    else $error("insert overwrote an occupied slot");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.probe_init || cmd.probe_adv) |=> (pos_r < size_eff))
    else $error("probe slot outside the table");

endmodule

// ===== design/quadratic_probe_hash_table_top.sv =====
// Top level of the quadratic-probe hash table keyed by money amounts.
// Depends on qph_pkg, qph_ctrl, qph_dp (and qph_ram through qph_dp).
//
// Usage:
//   Input beats on in_*: tuser is the opcode (0 insert, 1 search), tdata
//   carries the key as whole units and cents. Each beat yields exactly one
//   result beat on out_*: tuser is the status, tdata the slot index, the
//   occupied-slot count and the saturating collision count.
//   One item is in work at a time. After acceptance the home slot is reduced
//   modulo the size (3 remainder bits per cycle), then the probe walk runs:
//   an insert checks the occupancy bits only, a search does a registered key
//   RAM read, then a compare for each probe. The block is ready for the next
//   beat once the result has been moved into the output register.
//   The result sits in an output register; a new beat is accepted while it
//   waits, and the block holds the next result until the register is free.
//   Reset empties the table, clears both counts and sets the size to 29;
//   a write on cfg_wr_en does the same with the new size, and must be made
//   only while the block is idle.
module quadratic_probe_hash_table_top #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: key_whole[15:0], key_cents[22:16], zero [23]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [qph_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: opcode[0]
  input  logic                               in_tuser,
  // out_tdata: slot_index[5:0], entry_total[12:6], collision_total[28:13],
  // zero [31:29]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qph_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: status[1:0]
  output logic [qph_pkg::STATUS_W-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [qph_pkg::SIZE_W-1:0]         cfg_wr_data
);
  import qph_pkg::*;

  qph_cmd_t  cmd;
  qph_stat_t stat;

  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qph_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== bench/quadratic_probe_hash_table_top_test.sv =====
// Self-checking bench for quadratic_probe_hash_table_top: a scoreboard class keeps its own
// copy of the slots and predicts each insert or search result; plain tasks drive the streams.
// Depends on qph_pkg and the design sources of the hash table.
module quadratic_probe_hash_table_top_test;
  import qph_pkg::*;

  localparam int SLOTS_MAX    = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    status_t      status;
    logic [5:0]   slot_index;
    logic [6:0]   entry_total;
    logic [15:0]  collision_total;
  } probe_result_t;

  // Shadow of the slot array plus the queue of results still owed by the block
  class probe_scoreboard;
    bit                occupied[SLOTS_MAX];
    logic [KEY_W-1:0]  stored_key[SLOTS_MAX];
    int unsigned       entries;
    int unsigned       collisions;
    logic [SIZE_W-1:0] size_reg;
    probe_result_t     results_due[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       checked;
    int unsigned       status_seen[4];

    function new();
      write_size(SIZE_RESET);
    endfunction

    // A size write empties every slot and clears both counts
    function void write_size(logic [SIZE_W-1:0] value);
      size_reg = value;
      foreach (occupied[i]) occupied[i] = 1'b0;
      entries    = 0;
      collisions = 0;
    endfunction

    // Walk the probe path for one accepted beat and queue the result it owes
    function void note_request(logic op, logic [WHOLE_W-1:0] whole,
                               logic [CENTS_W-1:0] cents);
      int unsigned   hundredths;
      int unsigned   home;
      int unsigned   modulus;
      int unsigned   pos;
      int unsigned   probe;
      bit            done;
      probe_result_t res;
      hundredths = int'(whole) * 100 + int'(cents);
      home       = 2 * (hundredths / 100) + 3 * (hundredths % 100);
      modulus    = (size_reg == 0) ? 1 : (size_reg > SLOTS_MAX) ? SLOTS_MAX : size_reg;
      res.slot_index = '0;
      done = 1'b0;
      if (op == OP_INSERT) begin
        res.status = ST_FULL;
        for (probe = 0; probe < modulus && !done; probe++) begin
          pos = (home + probe + probe * probe) % modulus;
          if (!occupied[pos]) begin
            occupied[pos]   = 1'b1;
            stored_key[pos] = hundredths[KEY_W-1:0];
            entries++;
            res.status     = ST_INSERTED;
            res.slot_index = pos[5:0];
            done = 1'b1;
          end else if (collisions < 16'hFFFF) begin
            collisions++;
          end
        end
      end else begin
        // search gives up after one probe more than the size
        res.status = ST_MISSING;
        for (probe = 0; probe <= modulus && !done; probe++) begin
          pos = (home + probe + probe * probe) % modulus;
          if (!occupied[pos]) begin
            done = 1'b1;
          end else if (stored_key[pos] == hundredths[KEY_W-1:0]) begin
            res.status     = ST_FOUND;
            res.slot_index = pos[5:0];
            done = 1'b1;
          end
        end
      end
      res.entry_total     = entries[6:0];
      res.collision_total = collisions[15:0];
      results_due.push_back(res);
      requests++;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 50)
          $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                   $time, field, checked, want, got);
      end
    endfunction

    // Compare one accepted result beat against the oldest owed result
    function void check_response(status_t status, logic [OUT_TDATA_W-1:0] data);
      probe_result_t want;
      checked++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result beat, expected none, got status %0d data 0x%08h",
                   $time, status, data);
        return;
      end
      want = results_due.pop_front();
      status_seen[want.status]++;
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("slot_index", 32'(want.slot_index), 32'(data[5:0]));
      compare_field("entry_total", 32'(want.entry_total), 32'(data[12:6]));
      compare_field("collision_total", 32'(want.collision_total), 32'(data[28:13]));
      compare_field("tdata padding", 32'd0, 32'(data[31:29]));
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0]      cfg_wr_data = '0;

  probe_scoreboard    sb = new();
  logic [WHOLE_W-1:0] stored_whole[$];
  logic [CENTS_W-1:0] stored_cents[$];
  bit                 send_burst   = 1'b0;
  bit                 recv_burst   = 1'b0;
  int unsigned        sizes_set    = 0;
  int unsigned        cycles       = 0;

  quadratic_probe_hash_table_top #(
    .MAX_SLOTS(SLOTS_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, sb.results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_item(input logic op, input logic [WHOLE_W-1:0] whole,
                           input logic [CENTS_W-1:0] cents);
    int gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = $urandom_range(0, 17);
    if (send_burst) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, cents, whole};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, whole, cents);
  endtask

  // Drain the block, then write a new size
  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_size(value);
    sizes_set++;
  endtask

  // Random key: mostly anywhere, some small, some at the extremes, some cents past 99
  function automatic void pick_key(output logic [WHOLE_W-1:0] whole,
                                   output logic [CENTS_W-1:0] cents);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) whole = WHOLE_W'($urandom_range(0, 15));
    else if (roll < 35) whole = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else whole = WHOLE_W'($urandom_range(0, 65535));
    cents = CENTS_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 99)
                                                   : $urandom_range(100, 127));
  endfunction

  // Mix of fresh inserts, duplicate inserts, searches for stored keys and for random keys
  task automatic run_random_phase(input int count);
    logic [WHOLE_W-1:0] whole;
    logic [CENTS_W-1:0] cents;
    int unsigned        pick;
    int unsigned        hundredths;
    int unsigned        roll;
    stored_whole.delete();
    stored_cents.delete();
    repeat (count) begin
      roll = $urandom_range(0, 99);
      pick_key(whole, cents);
      if (roll >= 45 && roll < 85 && stored_whole.size() != 0) begin
        pick  = $urandom_range(0, stored_whole.size() - 1);
        whole = stored_whole[pick];
        cents = stored_cents[pick];
        // spell some searched keys with the surplus hundred carried into the cents
        hundredths = int'(whole) * 100 + int'(cents);
        if (roll >= 55 && $urandom_range(0, 1) == 1 && hundredths >= 100 &&
            hundredths % 100 < 28) begin
          whole = WHOLE_W'(hundredths / 100 - 1);
          cents = CENTS_W'(hundredths % 100 + 100);
        end
      end
      if (roll < 45) begin
        stored_whole.push_back(whole);
        stored_cents.push_back(cents);
      end
      send_item((roll < 55) ? OP_INSERT : OP_SEARCH, whole, cents);
    end
  endtask

  // Result side: random stalls, bursts of back-to-back accepts, and long hold-offs
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      gap = $urandom_range(0, 17);
      if (recv_burst) gap = 0;
      if (sb.checked % 500 == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_response(out_tuser, out_tdata);
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_sizes[12];
    phase_sizes = '{7'd1, 7'd64, 7'd2, 7'd97, 7'd31, 7'd8, 7'd50, 7'd5, 7'd120, 7'd17,
                    7'd0, 7'd0};
    phase_sizes[10] = SIZE_W'($urandom_range(0, 127));
    phase_sizes[11] = SIZE_W'($urandom_range(1, 64));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size: key extremes, cents carry, duplicates, hits and misses
    send_item(OP_INSERT, 16'd0, 7'd0);
    send_item(OP_INSERT, 16'hFFFF, 7'd99);
    send_item(OP_INSERT, 16'd0, 7'd127);
    send_item(OP_SEARCH, 16'd1, 7'd27);
    send_item(OP_INSERT, 16'd0, 7'd0);
    send_item(OP_SEARCH, 16'd0, 7'd0);
    send_item(OP_SEARCH, 16'hFFFF, 7'd127);
    send_item(OP_INSERT, 16'hFFFF, 7'd127);
    send_item(OP_SEARCH, 16'hFFFF, 7'd127);
    send_item(OP_SEARCH, 16'd5, 7'd5);
    send_item(OP_INSERT, 16'd0, 7'd99);
    send_item(OP_SEARCH, 16'd0, 7'd99);

    // Size zero acts as one slot: fill it, overflow, and run out the search limit
    write_table_size(7'd0);
    send_item(OP_INSERT, 16'd7, 7'd7);
    send_item(OP_INSERT, 16'd8, 7'd8);
    send_item(OP_SEARCH, 16'd8, 7'd8);
    send_item(OP_SEARCH, 16'd7, 7'd7);

    // Oversized setting clamps to the full slot count
    write_table_size(7'd127);
    send_item(OP_INSERT, 16'hFFFF, 7'd127);
    send_item(OP_SEARCH, 16'hFFFF, 7'd127);
    send_item(OP_INSERT, 16'd12, 7'd34);
    send_item(OP_SEARCH, 16'd12, 7'd34);

    foreach (phase_sizes[p]) begin
      write_table_size(phase_sizes[p]);
      run_random_phase(PHASE_ITEMS);
    end

    // Let the last results drain
    in_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests across %0d size settings, %0d result beats checked.",
             sb.requests, sizes_set + 1, sb.checked);
    $display("Outcomes: %0d inserted, %0d full, %0d found, %0d not found; %0d mismatches.",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_FOUND], sb.status_seen[ST_MISSING], sb.errors);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== quadratic_probe_hash_table_top.f =====
design/qph_pkg.sv
design/qph_ram.sv
design/qph_ctrl.sv
design/qph_dp.sv
design/quadratic_probe_hash_table_top.sv
bench/quadratic_probe_hash_table_top_test.sv
